// File: sv/dps_pkg.sv
// Shared types and constants for the dynamic priority scheduler.
`default_nettype none

package dps_pkg;

  // Default ready-queue depth
  localparam int unsigned DPS_DEPTH_DEFAULT = 16;

  // Command codes
  localparam logic CMD_ADD  = 1'b0;
  localparam logic CMD_TICK = 1'b1;

  // Status codes
  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_FULL  = 2'd1;
  localparam logic [1:0] ST_EMPTY = 2'd2;

  // One queue entry as stored in the entry RAM
  typedef struct packed {
    logic [7:0]        id;
    logic signed [7:0] pri;
    logic [7:0]        need;
    logic [7:0]        ran;
  } dps_entry_t;

  localparam int unsigned ENTRY_W = $bits(dps_entry_t);

  // Sequencer states, one-hot
  typedef enum logic [5:0] {
    S_IDLE      = 6'b000001,
    S_HEAD_WAIT = 6'b000010,
    S_INS_START = 6'b000100,
    S_INS_WAIT  = 6'b001000,
    S_INS_LAST  = 6'b010000,
    S_RESP      = 6'b100000
  } dps_state_e;

endpackage

`default_nettype wire

// File: sv/dps_ram.sv
// Generic simple dual-port RAM: one write port, one read port with registered data.
`default_nettype none

module dps_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 16,
  localparam int unsigned AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AW-1:0]    waddr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  input  wire logic [AW-1:0]    raddr_i,
  output logic      [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port
  always_ff @(posedge clk_i) begin
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// File: sv/dynamic_priority_scheduler.sv
// Top level of the dynamic priority scheduler: sequencer around a circular entry RAM.
//
//  channel   | signals                                          | direction | handshake
//  ----------+--------------------------------------------------+-----------+---------------------
//  command   | cmd_i proc_id_i new_priority_i needed_time_i     | in        | start & !busy
//  result    | status_o run_id_o run_priority_o run_count_o     | out       | done_o, one cycle
//            | finished_o waiting_left_o                        |           |
//
//  An add walks from the tail toward the head, moving each lower-priority entry back a slot
//  to open its own; a tick reads the head entry, retires it once its run count reaches its
//  need, else requeues it like an add with priority lowered by one. Refused adds and empty
//  ticks go straight to the result. busy holds through the result cycle as well.
//  Reset clears the fill count, head pointer, state and results; never the entry RAM.
//  The result is shown for exactly one cycle on done_o; the receiver cannot stall it.
`default_nettype none

module dynamic_priority_scheduler #(
  parameter int unsigned QUEUE_DEPTH = dps_pkg::DPS_DEPTH_DEFAULT
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              start,
  output logic                   busy,
  input  wire logic              cmd_i,
  input  wire logic [7:0]        proc_id_i,
  input  wire logic signed [7:0] new_priority_i,
  input  wire logic [7:0]        needed_time_i,
  output logic                   done_o,
  output logic      [1:0]        status_o,
  output logic      [7:0]        run_id_o,
  output logic signed [7:0]      run_priority_o,
  output logic      [7:0]        run_count_o,
  output logic                   finished_o,
  output logic      [4:0]        waiting_left_o
);

  import dps_pkg::*;

  localparam int unsigned PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned CW = $clog2(QUEUE_DEPTH + 1);
  localparam int unsigned SW = CW + 1;

  dps_state_e        state_q, state_d;
  logic [PW-1:0]     head_q, head_d;
  logic [CW-1:0]     count_q, count_d;
  logic [PW-1:0]     hole_q, hole_d;
  logic [PW-1:0]     scan_q, scan_d;
  logic [CW-1:0]     left_q, left_d;
  dps_entry_t        rec_q, rec_d;
  logic [1:0]        status_q, status_d;
  logic [7:0]        run_id_q, run_id_d;
  logic signed [7:0] run_pri_q, run_pri_d;
  logic [7:0]        run_cnt_q, run_cnt_d;
  logic              fin_q, fin_d;

  // RAM ports
  logic              ram_we;
  logic [PW-1:0]     ram_waddr;
  dps_entry_t        ram_wdata;
  logic [PW-1:0]     ram_raddr;
  logic [ENTRY_W-1:0] ram_rdata;
  dps_entry_t        rd;

  // Pointer arithmetic
  logic [SW-1:0]     tail_sum;
  logic [PW-1:0]     tail;
  logic [PW-1:0]     tail_dec;
  logic [PW-1:0]     scan_dec;
  logic [PW-1:0]     head_inc;
  logic [7:0]        head_ran;
  logic signed [7:0] head_pri_dn;
  logic              accept;

  assign rd     = dps_entry_t'(ram_rdata);
  assign accept = start && !busy;

  // Tail slot = head + count, wrapped once
  assign tail_sum = SW'(head_q) + SW'(count_q);
  assign tail     = (tail_sum >= SW'(QUEUE_DEPTH)) ? PW'(tail_sum - SW'(QUEUE_DEPTH))
                                                   : PW'(tail_sum);
  assign tail_dec = (tail == '0) ? PW'(QUEUE_DEPTH - 1) : tail - PW'(1);
  assign scan_dec = (scan_q == '0) ? PW'(QUEUE_DEPTH - 1) : scan_q - PW'(1);
  assign head_inc = (head_q == PW'(QUEUE_DEPTH - 1)) ? '0 : head_q + PW'(1);

  // Head entry update for a tick
  assign head_ran    = rd.ran + 8'd1;
  assign head_pri_dn = (rd.pri == -8'sd128) ? rd.pri : rd.pri - 8'sd1;

  // Sequencer
  always_comb begin
    state_d   = state_q;
    head_d    = head_q;
    count_d   = count_q;
    hole_d    = hole_q;
    scan_d    = scan_q;
    left_d    = left_q;
    rec_d     = rec_q;
    status_d  = status_q;
    run_id_d  = run_id_q;
    run_pri_d = run_pri_q;
    run_cnt_d = run_cnt_q;
    fin_d     = fin_q;
    ram_we    = 1'b0;
    ram_waddr = hole_q;
    ram_wdata = rec_q;
    ram_raddr = head_q;

    case (state_q)
      S_IDLE: begin
        if (accept) begin
          status_d  = ST_OK;
          run_id_d  = '0;
          run_pri_d = '0;
          run_cnt_d = '0;
          fin_d     = 1'b0;
          if (cmd_i == CMD_ADD) begin
            rec_d.id   = proc_id_i;
            rec_d.pri  = new_priority_i;
            rec_d.need = (needed_time_i == 8'd0) ? 8'd1 : needed_time_i;
            rec_d.ran  = 8'd0;
            if (count_q == CW'(QUEUE_DEPTH)) begin
              status_d = ST_FULL;
              state_d  = S_RESP;
            end else begin
              state_d  = S_INS_START;
            end
          end else if (count_q == '0) begin
            status_d = ST_EMPTY;
            state_d  = S_RESP;
          end else begin
            // head read issued on ram_raddr default
            state_d = S_HEAD_WAIT;
          end
        end
      end

      S_HEAD_WAIT: begin
        run_id_d  = rd.id;
        run_pri_d = rd.pri;
        run_cnt_d = head_ran;
        head_d    = head_inc;
        count_d   = count_q - CW'(1);
        if (head_ran >= rd.need) begin
          fin_d   = 1'b1;
          state_d = S_RESP;
        end else begin
          rec_d.id   = rd.id;
          rec_d.pri  = head_pri_dn;
          rec_d.need = rd.need;
          rec_d.ran  = head_ran;
          state_d    = S_INS_START;
        end
      end

      S_INS_START: begin
        if (count_q == '0) begin
          ram_we    = 1'b1;
          ram_waddr = tail;
          count_d   = count_q + CW'(1);
          state_d   = S_RESP;
        end else begin
          hole_d    = tail;
          scan_d    = tail_dec;
          left_d    = count_q;
          ram_raddr = tail_dec;
          state_d   = S_INS_WAIT;
        end
      end

      // Walk from the tail toward the head, moving lower priorities back
      S_INS_WAIT: begin
        ram_we = 1'b1;
        if (rd.pri >= rec_q.pri) begin
          count_d = count_q + CW'(1);
          state_d = S_RESP;
        end else begin
          ram_wdata = rd;
          hole_d    = scan_q;
          left_d    = left_q - CW'(1);
          if (left_q == CW'(1)) begin
            state_d = S_INS_LAST;
          end else begin
            scan_d    = scan_dec;
            ram_raddr = scan_dec;
          end
        end
      end

      S_INS_LAST: begin
        ram_we  = 1'b1;
        count_d = count_q + CW'(1);
        state_d = S_RESP;
      end

      S_RESP: begin
        state_d = S_IDLE;
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      head_q    <= '0;
      count_q   <= '0;
      status_q  <= ST_OK;
      run_id_q  <= '0;
      run_pri_q <= '0;
      run_cnt_q <= '0;
      fin_q     <= 1'b0;
    end else begin
      state_q   <= state_d;
      head_q    <= head_d;
      count_q   <= count_d;
      status_q  <= status_d;
      run_id_q  <= run_id_d;
      run_pri_q <= run_pri_d;
      run_cnt_q <= run_cnt_d;
      fin_q     <= fin_d;
    end
  end

  // Scan payload
  always_ff @(posedge clk_i) begin
    hole_q <= hole_d;
    scan_q <= scan_d;
    left_q <= left_d;
    rec_q  <= rec_d;
  end

  dps_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (QUEUE_DEPTH)
  ) u_entry_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // Outputs
  assign busy           = (state_q != S_IDLE);
  assign done_o         = (state_q == S_RESP);
  assign status_o       = status_q;
  assign run_id_o       = run_id_q;
  assign run_priority_o = run_pri_q;
  assign run_count_o    = run_cnt_q;
  assign finished_o     = fin_q;
  assign waiting_left_o = 5'(count_q);

  // Checks
  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CW'(QUEUE_DEPTH))
    else $error("queue fill above depth");

  a_full_drop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && status_o == ST_FULL) |-> count_q == CW'(QUEUE_DEPTH))
    else $error("full status with room left");

  a_empty_tick: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && status_o == ST_EMPTY) |-> (count_q == '0 && run_id_o == '0))
    else $error("empty status with entries queued");

  a_finish_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && finished_o) |-> (status_o == ST_OK && run_count_o != 8'd0))
    else $error("retired item with bad status");

  a_insert_slot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_INS_START) |-> count_q != CW'(QUEUE_DEPTH))
    else $error("insert started on full queue");

endmodule

`default_nettype wire
